>>> rtl/ntrk_pkg.sv
package ntrk_pkg;

    localparam int KIND_W      = 3;
    localparam int CH_W        = 4;
    localparam int PITCH_W     = 7;
    localparam int VEL_W       = 16;
    localparam int VEL7_W      = 7;
    localparam int OFFSET_W    = 31;
    localparam int OVERLAP_W   = 16;
    localparam int CAP_W       = 6;
    localparam int DROP_W      = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int KEYS_PER_CH = 128;
    localparam int KEY_W       = CH_W + PITCH_W;

    localparam logic [OVERLAP_W-1:0] OVERLAP_RESET = 16'd16;
    localparam logic [CAP_W-1:0]     CAP_RESET     = 6'd63;
    localparam logic [23:0]          VEL_ROUND     = 24'd32767;

    localparam logic [KIND_W-1:0] KIND_NOTE_OFF    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NOTE_ON     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH       = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BLOCK_START = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RESET       = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_OVERLAP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_CAPACITY = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_KEY,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_STATUS
    } ntrk_state_t;

    typedef struct packed {
        logic                is_status;
        logic                note_on;
        logic [CH_W-1:0]     out_channel;
        logic [PITCH_W-1:0]  out_pitch;
        logic [VEL7_W-1:0]   velocity_7bit;
        logic [VEL_W-1:0]    velocity_16bit;
        logic [OFFSET_W-1:0] out_offset;
        logic                accepted;
        logic                overflowed;
        logic                flush_pending;
        logic                any_active;
        logic                last;
    } ntrk_evt_t;

endpackage

>>> rtl/ntrk_cmd_if.sv
interface ntrk_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [ntrk_pkg::KIND_W-1:0]         kind;
    logic [ntrk_pkg::CH_W-1:0]           channel;
    logic [ntrk_pkg::PITCH_W-1:0]        pitch;
    logic [ntrk_pkg::VEL_W-1:0]          velocity;
    logic [ntrk_pkg::OFFSET_W-1:0]       sample_pos;

    modport source (
        output valid, kind, channel, pitch, velocity, sample_pos,
        input  ready
    );
    modport sink (
        input  valid, kind, channel, pitch, velocity, sample_pos,
        output ready
    );
endinterface

>>> rtl/ntrk_evt_if.sv
interface ntrk_evt_if;
    logic                                valid;
    logic                                ready;
    logic                                is_status;
    logic                                note_on;
    logic [ntrk_pkg::CH_W-1:0]           out_channel;
    logic [ntrk_pkg::PITCH_W-1:0]        out_pitch;
    logic [ntrk_pkg::VEL7_W-1:0]         velocity_7bit;
    logic [ntrk_pkg::VEL_W-1:0]          velocity_16bit;
    logic [ntrk_pkg::OFFSET_W-1:0]       out_offset;
    logic                                accepted;
    logic                                overflowed;
    logic                                flush_pending;
    logic                                any_active;
    logic                                last;

    modport source (
        output valid, is_status, note_on, out_channel, out_pitch, velocity_7bit,
               velocity_16bit, out_offset, accepted, overflowed, flush_pending,
               any_active, last,
        input  ready
    );
    modport sink (
        input  valid, is_status, note_on, out_channel, out_pitch, velocity_7bit,
               velocity_16bit, out_offset, accepted, overflowed, flush_pending,
               any_active, last,
        output ready
    );
endinterface

>>> rtl/ntrk_cfg_if.sv
interface ntrk_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [ntrk_pkg::CFG_IDX_W-1:0]      index;
    logic [ntrk_pkg::CFG_DATA_W-1:0]     data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

>>> rtl/ntrk_ram.sv
module ntrk_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/note_overlap_tracker_top.sv
// Note on/off: ST_KEY, then ST_STATUS; a note beat when emitted, a flush on overflow.
// Flush: each key of the count store is read (ST_SCAN_RD), then checked (ST_SCAN_CHK).
// One item at a time; cmd.ready is high only between items. The count store has one
// read and one write port, which sets the per-key scan rate.
// After rst_n and after a reset command a clearing pass writes CHANNELS*128 zero entries,
// one per cycle, with cmd.ready low; configuration writes are taken at all times.
module note_overlap_tracker_top #(
    parameter int CHANNELS    = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    ntrk_cmd_if.sink     cmd,
    ntrk_evt_if.source   evt,
    ntrk_cfg_if.sink     cfg
);

    import ntrk_pkg::*;

    localparam int NKEYS = CHANNELS * KEYS_PER_CH;
    localparam int AW    = $clog2(NKEYS);
    localparam int AKW   = $clog2(NKEYS + 1);
    localparam logic [AW-1:0]        LAST_KEY  = AW'(NKEYS - 1);
    localparam logic [AKW-1:0]       KEY_TOTAL = AKW'(NKEYS);
    localparam logic [CH_W:0]        CH_LIMIT  = (CH_W + 1)'(CHANNELS);
    localparam logic [OVERLAP_W-1:0] COUNT_MAX =
        OVERLAP_W'((32'd1 << COUNT_WIDTH) - 32'd1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

    ntrk_state_t state_reg, state_next;

    logic [AW-1:0]          addr_reg, addr_next;
    logic [KIND_W-1:0]      kind_reg, kind_next;
    logic [CH_W-1:0]        ch_reg, ch_next;
    logic [PITCH_W-1:0]     pitch_reg, pitch_next;
    logic [VEL_W-1:0]       vel_reg, vel_next;
    logic [VEL7_W-1:0]      vel7_reg, vel7_next;
    logic [OFFSET_W-1:0]    offset_reg, offset_next;
    logic                   ok_reg, ok_next;
    logic                   clr_item_reg, clr_item_next;
    logic [AKW-1:0]         active_reg, active_next;
    logic [CAP_W-1:0]       events_reg, events_next;
    logic [DROP_W-1:0]      dropped_reg, dropped_next;
    logic                   overflow_reg, overflow_next;
    logic                   pending_reg, pending_next;
    logic [OVERLAP_W-1:0]   max_overlap_reg, max_overlap_next;
    logic [CAP_W-1:0]       block_cap_reg, block_cap_next;
    logic                   out_valid_reg, out_valid_next;
    ntrk_evt_t              out_reg, out_next;

    logic                   cmd_accept;
    logic                   slot_free;
    logic                   out_load;
    logic                   room;
    logic                   drop;
    logic                   inc_active;
    logic                   dec_active;
    logic                   count_event;
    logic                   last_key;
    logic                   ch_ok;
    logic [KEY_W-1:0]       cmd_key;
    logic [KEY_W-1:0]       scan_key;
    logic [OVERLAP_W-1:0]   limit;
    logic [OVERLAP_W-1:0]   count_wide;
    logic [22:0]            vel_prod;
    logic [23:0]            vel_x;
    logic [23:0]            vel_sum;
    logic [VEL7_W-1:0]      vel_q;

    logic                   ram_we;
    logic [AW-1:0]          ram_raddr;
    logic [COUNT_WIDTH-1:0] ram_wdata;
    logic [COUNT_WIDTH-1:0] ram_rdata;

    ntrk_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NKEYS)
    ) u_counts (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cmd.ready  = (state_reg == ST_IDLE);
    assign cmd_accept = cmd.valid && cmd.ready;
    assign cfg.ready  = 1'b1;
    assign slot_free  = !out_valid_reg || evt.ready;
    assign room       = (events_reg < block_cap_reg);
    assign last_key   = (addr_reg == LAST_KEY);
    assign cmd_key    = {cmd.channel, cmd.pitch};
    assign scan_key   = KEY_W'(addr_reg);
    assign ch_ok      = ({1'b0, cmd.channel} < CH_LIMIT);
    assign ram_raddr  = (state_reg == ST_IDLE) ? cmd_key[AW-1:0] : addr_reg;
    assign count_wide = OVERLAP_W'(ram_rdata);

    // divide by 65535: q = (x + (x >> 16) + 1) >> 16, exact below 2^32
    assign vel_prod = {cmd.velocity, 7'd0} - {7'd0, cmd.velocity};
    assign vel_x    = {1'b0, vel_prod} + VEL_ROUND;
    assign vel_sum  = vel_x + {16'd0, vel_x[23:16]} + 24'd1;
    assign vel_q    = vel_sum[22:16];

    always_comb
    begin
        if (max_overlap_reg > COUNT_MAX)
        begin
            limit = COUNT_MAX;
        end
        else if (max_overlap_reg == '0)
        begin
            limit = OVERLAP_W'(1);
        end
        else
        begin
            limit = max_overlap_reg;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        addr_next        = addr_reg;
        kind_next        = kind_reg;
        ch_next          = ch_reg;
        pitch_next       = pitch_reg;
        vel_next         = vel_reg;
        vel7_next        = vel7_reg;
        offset_next      = offset_reg;
        ok_next          = ok_reg;
        clr_item_next    = clr_item_reg;
        active_next      = active_reg;
        events_next      = events_reg;
        dropped_next     = dropped_reg;
        overflow_next    = overflow_reg;
        pending_next     = pending_reg;
        max_overlap_next = max_overlap_reg;
        block_cap_next   = block_cap_reg;
        out_next         = out_reg;
        out_load         = 1'b0;
        ram_we           = 1'b0;
        ram_wdata        = '0;
        drop             = 1'b0;
        inc_active       = 1'b0;
        dec_active       = 1'b0;
        count_event      = 1'b0;

        if (cfg.valid)
        begin
            if (cfg.index == CFG_MAX_OVERLAP)
            begin
                max_overlap_next = cfg.data;
            end
            else if (cfg.index == CFG_BLOCK_CAPACITY)
            begin
                block_cap_next = cfg.data[CAP_W-1:0];
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_accept)
                begin
                    kind_next   = cmd.kind;
                    ch_next     = cmd.channel;
                    pitch_next  = cmd.pitch;
                    vel_next    = cmd.velocity;
                    vel7_next   = (vel_q == '0) ? VEL7_W'(1) : vel_q;
                    offset_next = cmd.sample_pos;
                    addr_next   = cmd_key[AW-1:0];
                    priority case (cmd.kind)
                        KIND_NOTE_OFF, KIND_NOTE_ON:
                        begin
                            if (ch_ok)
                            begin
                                state_next = ST_KEY;
                            end
                            else
                            begin
                                ok_next    = 1'b0;
                                state_next = ST_STATUS;
                            end
                        end
                        KIND_FLUSH:
                        begin
                            addr_next  = '0;
                            state_next = ST_SCAN_RD;
                        end
                        KIND_BLOCK_START:
                        begin
                            events_next   = '0;
                            dropped_next  = '0;
                            overflow_next = 1'b0;
                            offset_next   = '0;
                            addr_next     = '0;
                            if (pending_reg)
                            begin
                                state_next = ST_SCAN_RD;
                            end
                            else
                            begin
                                ok_next    = 1'b1;
                                state_next = ST_STATUS;
                            end
                        end
                        KIND_RESET:
                        begin
                            active_next   = '0;
                            events_next   = '0;
                            dropped_next  = '0;
                            overflow_next = 1'b0;
                            pending_next  = 1'b0;
                            ok_next       = 1'b1;
                            addr_next     = '0;
                            clr_item_next = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        default:
                        begin
                            ok_next    = 1'b0;
                            state_next = ST_STATUS;
                        end
                    endcase
                end
            end

            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (last_key)
                begin
                    addr_next     = '0;
                    clr_item_next = 1'b0;
                    state_next    = clr_item_reg ? ST_STATUS : ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + AW'(1);
                end
            end

            ST_KEY:
            begin
                if (kind_reg == KIND_NOTE_OFF)
                begin
                    if (ram_rdata == '0)
                    begin
                        ok_next    = 1'b1;
                        state_next = ST_STATUS;
                    end
                    else if (ram_rdata != COUNT_ONE)
                    begin
                        ram_we     = 1'b1;
                        ram_wdata  = ram_rdata - COUNT_ONE;
                        ok_next    = 1'b1;
                        state_next = ST_STATUS;
                    end
                    else if (!room)
                    begin
                        drop       = 1'b1;
                        ok_next    = 1'b0;
                        state_next = ST_STATUS;
                    end
                    else if (slot_free)
                    begin
                        out_load            = 1'b1;
                        out_next            = '0;
                        out_next.out_channel = ch_reg;
                        out_next.out_pitch  = pitch_reg;
                        out_next.out_offset = offset_reg;
                        ram_we              = 1'b1;
                        ram_wdata           = '0;
                        dec_active          = 1'b1;
                        count_event         = 1'b1;
                        ok_next             = 1'b1;
                        state_next          = ST_STATUS;
                    end
                end
                else if (ram_rdata != '0)
                begin
                    if (count_wide >= limit)
                    begin
                        overflow_next = 1'b1;
                        pending_next  = 1'b1;
                        addr_next     = '0;
                        state_next    = ST_SCAN_RD;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        ram_wdata  = ram_rdata + COUNT_ONE;
                        ok_next    = 1'b1;
                        state_next = ST_STATUS;
                    end
                end
                else if (!room)
                begin
                    drop       = 1'b1;
                    ok_next    = 1'b0;
                    state_next = ST_STATUS;
                end
                else if (slot_free)
                begin
                    out_load               = 1'b1;
                    out_next               = '0;
                    out_next.note_on       = 1'b1;
                    out_next.out_channel   = ch_reg;
                    out_next.out_pitch     = pitch_reg;
                    out_next.velocity_7bit = vel7_reg;
                    out_next.velocity_16bit = vel_reg;
                    out_next.out_offset    = offset_reg;
                    ram_we                 = 1'b1;
                    ram_wdata              = COUNT_ONE;
                    inc_active             = 1'b1;
                    count_event            = 1'b1;
                    ok_next                = 1'b1;
                    state_next             = ST_STATUS;
                end
            end

            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_CHK;
            end

            ST_SCAN_CHK:
            begin
                if (ram_rdata == '0)
                begin
                    if (last_key)
                    begin
                        pending_next = 1'b0;
                        ok_next      = (kind_reg != KIND_NOTE_ON);
                        state_next   = ST_STATUS;
                    end
                    else
                    begin
                        addr_next  = addr_reg + AW'(1);
                        state_next = ST_SCAN_RD;
                    end
                end
                else if (!room)
                begin
                    drop         = 1'b1;
                    pending_next = 1'b1;
                    ok_next      = 1'b0;
                    state_next   = ST_STATUS;
                end
                else if (slot_free)
                begin
                    out_load             = 1'b1;
                    out_next             = '0;
                    out_next.out_channel = scan_key[KEY_W-1:PITCH_W];
                    out_next.out_pitch   = scan_key[PITCH_W-1:0];
                    out_next.out_offset  = offset_reg;
                    ram_we               = 1'b1;
                    ram_wdata            = '0;
                    dec_active           = 1'b1;
                    count_event          = 1'b1;
                    if (last_key)
                    begin
                        pending_next = 1'b0;
                        ok_next      = (kind_reg != KIND_NOTE_ON);
                        state_next   = ST_STATUS;
                    end
                    else
                    begin
                        addr_next  = addr_reg + AW'(1);
                        state_next = ST_SCAN_RD;
                    end
                end
            end

            ST_STATUS:
            begin
                if (slot_free)
                begin
                    out_load               = 1'b1;
                    out_next               = '0;
                    out_next.is_status     = 1'b1;
                    out_next.accepted      = ok_reg;
                    out_next.overflowed    = overflow_reg;
                    out_next.flush_pending = pending_reg;
                    out_next.any_active    = (active_reg != '0);
                    out_next.last          = 1'b1;
                    state_next             = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (drop && (dropped_reg != '1))
        begin
            dropped_next = dropped_reg + DROP_W'(1);
        end
        if (count_event)
        begin
            events_next = events_reg + CAP_W'(1);
        end
        if (inc_active)
        begin
            active_next = active_reg + AKW'(1);
        end
        else if (dec_active && (active_reg != '0))
        begin
            active_next = active_reg - AKW'(1);
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (evt.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            addr_reg        <= '0;
            ok_reg          <= 1'b0;
            clr_item_reg    <= 1'b0;
            active_reg      <= '0;
            events_reg      <= '0;
            dropped_reg     <= '0;
            overflow_reg    <= 1'b0;
            pending_reg     <= 1'b0;
            max_overlap_reg <= OVERLAP_RESET;
            block_cap_reg   <= CAP_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            addr_reg        <= addr_next;
            ok_reg          <= ok_next;
            clr_item_reg    <= clr_item_next;
            active_reg      <= active_next;
            events_reg      <= events_next;
            dropped_reg     <= dropped_next;
            overflow_reg    <= overflow_next;
            pending_reg     <= pending_next;
            max_overlap_reg <= max_overlap_next;
            block_cap_reg   <= block_cap_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        ch_reg     <= ch_next;
        pitch_reg  <= pitch_next;
        vel_reg    <= vel_next;
        vel7_reg   <= vel7_next;
        offset_reg <= offset_next;
        out_reg    <= out_next;
    end

    assign evt.valid          = out_valid_reg;
    assign evt.is_status      = out_reg.is_status;
    assign evt.note_on        = out_reg.note_on;
    assign evt.out_channel    = out_reg.out_channel;
    assign evt.out_pitch      = out_reg.out_pitch;
    assign evt.velocity_7bit  = out_reg.velocity_7bit;
    assign evt.velocity_16bit = out_reg.velocity_16bit;
    assign evt.out_offset     = out_reg.out_offset;
    assign evt.accepted       = out_reg.accepted;
    assign evt.overflowed     = out_reg.overflowed;
    assign evt.flush_pending  = out_reg.flush_pending;
    assign evt.any_active     = out_reg.any_active;
    assign evt.last           = out_reg.last;

    // never overwrite a beat that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && out_valid_reg |-> evt.ready)
        else $error("output beat overwritten");

    a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg <= KEY_TOTAL)
        else $error("active key count beyond store size");

    a_event_room: assert property (@(posedge clk) disable iff (!rst_n)
        count_event |-> room)
        else $error("note beat sent with block full");

    a_on_counts: assert property (@(posedge clk) disable iff (!rst_n)
        inc_active |=> active_reg == $past(active_reg) + AKW'(1))
        else $error("note-on did not raise active key count");

    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !out_load && !cmd_accept)
        else $error("activity during clearing pass");

endmodule
